[design/bcrp_pkg.sv]
// Shared types and constants for the breadcrumb reverse path planner.
// No dependencies; every design file but bcrp_ram imports this package.
`timescale 1ns / 1ps

package bcrp_pkg;

    localparam int CRUMB_DEPTH_DEF = 32;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int DIST_W = 34;   // floor root, doubled when halved operands
    localparam int ACC_W  = 40;   // path length accumulators
    localparam int OUT_W  = 24;   // saturating length outputs
    localparam int CMP_W  = 8;    // small count compares
    localparam int CFG_W  = 24;

    localparam logic [OUT_W-1:0] MAX24 = {OUT_W{1'b1}};

    localparam logic [15:0] SPACING_RST  = 16'd51;
    localparam logic [23:0] HISTORY_RST  = 24'd3072;
    localparam logic [23:0] RECOVERY_RST = 24'd717;
    localparam logic [15:0] TOL_RST      = 16'd102;
    localparam logic [15:0] TIMEOUT_RST  = 16'd60;
    localparam logic [5:0]  LEAST_RST    = 6'd4;

    localparam logic [1:0] RUN_RECORD  = 2'd0;
    localparam logic [1:0] RUN_REVERSE = 2'd1;
    localparam logic [1:0] RUN_DONE    = 2'd2;
    localparam logic [1:0] RUN_FAIL    = 2'd3;

    localparam logic [2:0] WHY_RECORD  = 3'd0;
    localparam logic [2:0] WHY_FEW     = 3'd1;
    localparam logic [2:0] WHY_SHORT   = 3'd2;
    localparam logic [2:0] WHY_REVERSE = 3'd3;
    localparam logic [2:0] WHY_REACHED = 3'd4;
    localparam logic [2:0] WHY_TIMEOUT = 3'd5;

    typedef enum logic [1:0] {
        ACT_POSE = 2'd0,
        ACT_REQ  = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_SPACING  = 3'd0,
        CFG_HISTORY  = 3'd1,
        CFG_RECOVERY = 3'd2,
        CFG_TOL      = 3'd3,
        CFG_TIMEOUT  = 3'd4,
        CFG_LEAST    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {A_CUR, A_RAM, A_B} t_asel;
    typedef enum logic [1:0] {B_CUR, B_RAM, B_GOAL} t_bsel;
    typedef enum logic [1:0] {AD_CNT_M1, AD_CNT, AD_I_M1, AD_I_M2} t_addr;

    typedef enum logic [2:0] {
        ST_REC, ST_FEW, ST_SHORT, ST_PATHOK, ST_REACH, ST_TIMEOUT, ST_TRACK
    } t_stcode;

    typedef struct packed {
        logic    capture;
        logic    set_cur;
        logic    rec;
        logic    start_req;
        logic    fall_req;
        logic    tick_inc;
        logic    dist_go;
        logic    a_load;
        t_asel   a_sel;
        logic    b_load;
        t_bsel   b_sel;
        logic    rd_crumb;
        t_addr   addr_sel;
        logic    i_load_cnt;
        logic    i_dec;
        logic    len_clr;
        logic    len_add;
        logic    trim;
        logic    fail;
        logic    sp_init;
        logic    keep;
        logic    path_ok;
        logic    set_finished;
        logic    pt_rd;
        logic    pt_load;
        logic    st_load;
        t_stcode st_code;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    level;
        logic    have_pose;
        logic    req_active;
        logic    finished;
        logic    path_valid;
        logic    cnt_zero;
        logic    cnt_gt1;
        logic    i_pos;
        logic    i_gt2;
        logic    few;
        logic    dist_done;
        logic    d_ge_spacing;
        logic    len_over;
        logic    seg_short;
        logic    st_reach;
        logic    path_short;
        logic    at_goal;
        logic    timed_out;
        logic    out_free;
        logic    pt_more;
    } t_dp_stat;

endpackage

[design/bcrp_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bcrp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

[design/bcrp_dist.sv]
// Distance unit: floor(sqrt(dx*dx + dy*dy)), a squared-sum multiply, then a
// bit-pair root, one step per cycle. Depends on bcrp_pkg.
`timescale 1ns / 1ps

module bcrp_dist
    import bcrp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    output logic                          o_done,
    output logic [DIST_W-1:0]             o_dist
);
    typedef enum logic [2:0] {D_IDLE, D_MULA, D_MULB, D_ROOT, D_FIN} t_dstate;

    t_dstate     r_state;
    logic [4:0]  r_step;
    logic [31:0] r_opa, r_opb;
    logic        r_big;
    logic [63:0] r_prod, r_v, r_r, r_bit;

    logic signed [33:0] dx, dy;
    logic [33:0]        mx, my;
    logic               big;
    logic [63:0]        trial;

    always_comb begin
        dx = {{(34-COORD_WIDTH){i_ax[COORD_WIDTH-1]}}, i_ax}
           - {{(34-COORD_WIDTH){i_bx[COORD_WIDTH-1]}}, i_bx};
        dy = {{(34-COORD_WIDTH){i_ay[COORD_WIDTH-1]}}, i_ay}
           - {{(34-COORD_WIDTH){i_by[COORD_WIDTH-1]}}, i_by};
        mx = dx[33] ? 34'(-dx) : 34'(dx);
        my = dy[33] ? 34'(-dy) : 34'(dy);
        // halve both when either reaches 2^31
        big = (|mx[33:31]) | (|my[33:31]);
        trial = r_r + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                D_IDLE: if (i_go) r_state <= D_MULA;
                D_MULA: r_state <= D_MULB;
                D_MULB: begin
                    r_state <= D_ROOT;
                    r_step  <= '0;
                end
                D_ROOT: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd31) r_state <= D_FIN;
                end
                D_FIN: r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_go) begin
                    r_big <= big;
                    r_opa <= big ? mx[32:1] : mx[31:0];
                    r_opb <= big ? my[32:1] : my[31:0];
                end
            end
            D_MULA: r_prod <= r_opa * r_opa;
            D_MULB: begin
                r_v   <= r_prod + r_opb * r_opb;
                r_r   <= '0;
                r_bit <= 64'd1 << 62;
            end
            D_ROOT: begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == D_FIN);
    assign o_dist = r_big ? {r_r[32:0], 1'b0} : {1'b0, r_r[32:0]};
endmodule

[design/bcrp_dp.sv]
// Datapath: config registers, crumb ring, path buffer, distance unit,
// accumulators and the output register. Depends on bcrp_pkg, bcrp_ram, bcrp_dist.
`timescale 1ns / 1ps

module bcrp_dp
    import bcrp_pkg::*;
#(
    parameter int CRUMB_DEPTH = CRUMB_DEPTH_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic [1:0]                    i_action,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic                          i_request_level,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic [OUT_W-1:0]              o_station,
    output logic [1:0]                    o_run_state,
    output logic [2:0]                    o_reason,
    output logic                          o_ready_res,
    output logic [OUT_W-1:0]              o_remaining,
    output logic                          o_last
);
    localparam int IW  = $clog2(CRUMB_DEPTH);
    localparam int CNW = $clog2(CRUMB_DEPTH + 1);
    localparam int PNW = $clog2(CRUMB_DEPTH + 2);
    localparam int SW  = CNW + 1;
    localparam int CRW = 2 * COORD_WIDTH;
    localparam int PRW = CRW + OUT_W;

    // config
    logic [15:0] r_spacing, r_tol, r_timeout;
    logic [23:0] r_history, r_recovery;
    logic [5:0]  r_least;

    // control state
    logic [IW-1:0]  r_oldest;
    logic [CNW-1:0] r_count;
    logic           r_have_pose, r_active, r_finished, r_valid;
    logic [15:0]    r_elapsed;
    logic           r_out_valid;

    // working registers
    t_action                       r_action;
    logic                          r_level;
    logic signed [COORD_WIDTH-1:0] r_px, r_py, r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic signed [COORD_WIDTH-1:0] r_ax, r_ay, r_bx, r_by;
    logic [CNW-1:0]                r_i;
    logic [PNW-1:0]                r_n, r_k;
    logic [ACC_W-1:0]              r_len, r_station;

    logic                          dist_done;
    logic [DIST_W-1:0]             dist_q;
    logic [CRW-1:0]                crumb_q;
    logic [PRW-1:0]                path_q;
    logic signed [COORD_WIDTH-1:0] ram_x, ram_y;
    logic [IW-1:0]                 slot_rd, slot_cnt, slot_im2, slot_one;
    logic [CNW-1:0]                rd_off;
    logic [ACC_W-1:0]              d_ext, len_sum, st_sum;
    logic                          path_we;
    logic [CNW-1:0]                path_waddr;
    logic [PRW-1:0]                path_wdata;
    logic                          out_free;
    logic [1:0]                    st_run;
    logic [2:0]                    st_why;
    logic                          st_rdy;
    logic [ACC_W-1:0]              st_rem;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] oldest,
                                              input logic [CNW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(oldest) + SW'(off);
        if (s >= SW'(CRUMB_DEPTH)) s = s - SW'(CRUMB_DEPTH);
        return s[IW-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] sat24(input logic [ACC_W-1:0] v);
        return (v > ACC_W'(MAX24)) ? MAX24 : v[OUT_W-1:0];
    endfunction

    always_comb begin
        case (i_cmd.addr_sel)
            AD_CNT_M1: rd_off = r_count - CNW'(1);
            AD_CNT:    rd_off = r_count;
            AD_I_M1:   rd_off = r_i - CNW'(1);
            default:   rd_off = r_i - CNW'(2);
        endcase
        slot_rd  = slot_of(r_oldest, rd_off);
        slot_cnt = slot_of(r_oldest, r_count);
        slot_im2 = slot_of(r_oldest, r_i - CNW'(2));
        slot_one = slot_of(r_oldest, CNW'(1));
    end

    assign ram_x = crumb_q[CRW-1:COORD_WIDTH];
    assign ram_y = crumb_q[COORD_WIDTH-1:0];

    bcrp_ram #(.WIDTH(CRW), .DEPTH(CRUMB_DEPTH)) u_crumbs (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rec),
        .i_waddr (slot_cnt),
        .i_wdata ({r_cur_x, r_cur_y}),
        .i_re    (i_cmd.rd_crumb),
        .i_raddr (slot_rd),
        .o_rdata (crumb_q)
    );

    always_comb begin
        path_we    = i_cmd.sp_init | i_cmd.keep;
        path_waddr = i_cmd.sp_init ? '0 : r_n[CNW-1:0];
        path_wdata = i_cmd.sp_init ? {r_cur_x, r_cur_y, {OUT_W{1'b0}}}
                                   : {r_bx, r_by, sat24(st_sum)};
    end

    bcrp_ram #(.WIDTH(PRW), .DEPTH(CRUMB_DEPTH + 1)) u_path (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_waddr),
        .i_wdata (path_wdata),
        .i_re    (i_cmd.pt_rd),
        .i_raddr (r_k[CNW-1:0]),
        .o_rdata (path_q)
    );

    bcrp_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.dist_go),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .o_done  (dist_done),
        .o_dist  (dist_q)
    );

    assign d_ext    = ACC_W'(dist_q);
    assign len_sum  = r_len + d_ext;
    assign st_sum   = r_station + d_ext;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.action       = r_action;
        o_stat.level        = r_level;
        o_stat.have_pose    = r_have_pose;
        o_stat.req_active   = r_active;
        o_stat.finished     = r_finished;
        o_stat.path_valid   = r_valid;
        o_stat.cnt_zero     = (r_count == '0);
        o_stat.cnt_gt1      = (r_count > CNW'(1));
        o_stat.i_pos        = (r_i != '0);
        o_stat.i_gt2        = (r_i > CNW'(2));
        o_stat.few          = (CMP_W'(r_count) < CMP_W'(r_least));
        o_stat.dist_done    = dist_done;
        o_stat.d_ge_spacing = (d_ext >= ACC_W'(r_spacing));
        o_stat.len_over     = (len_sum > ACC_W'(r_history));
        o_stat.seg_short    = ((d_ext << 1) < ACC_W'(r_spacing));
        o_stat.st_reach     = (st_sum >= ACC_W'(r_recovery));
        o_stat.path_short   = (CMP_W'(r_n) < CMP_W'(r_least))
                           || ((r_station << 1) < ACC_W'(r_recovery));
        o_stat.at_goal      = (d_ext <= ACC_W'(r_tol));
        o_stat.timed_out    = (r_elapsed > r_timeout);
        o_stat.out_free     = out_free;
        o_stat.pt_more      = ((r_k + PNW'(1)) < r_n);
    end

    // status word contents
    always_comb begin
        unique case (i_cmd.st_code)
            ST_REC:     begin st_run = RUN_RECORD;  st_why = WHY_RECORD;  st_rdy = 1'b0; st_rem = '0;        end
            ST_FEW:     begin st_run = RUN_FAIL;    st_why = WHY_FEW;     st_rdy = 1'b0; st_rem = '0;        end
            ST_SHORT:   begin st_run = RUN_FAIL;    st_why = WHY_SHORT;   st_rdy = 1'b0; st_rem = r_station; end
            ST_PATHOK:  begin st_run = RUN_REVERSE; st_why = WHY_REVERSE; st_rdy = 1'b1; st_rem = r_station; end
            ST_REACH:   begin st_run = RUN_DONE;    st_why = WHY_REACHED; st_rdy = 1'b0; st_rem = d_ext;     end
            ST_TIMEOUT: begin st_run = RUN_FAIL;    st_why = WHY_TIMEOUT; st_rdy = 1'b0; st_rem = d_ext;     end
            default:    begin st_run = RUN_REVERSE; st_why = WHY_REVERSE; st_rdy = 1'b1; st_rem = d_ext;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing   <= SPACING_RST;
            r_history   <= HISTORY_RST;
            r_recovery  <= RECOVERY_RST;
            r_tol       <= TOL_RST;
            r_timeout   <= TIMEOUT_RST;
            r_least     <= LEAST_RST;
            r_oldest    <= '0;
            r_count     <= '0;
            r_have_pose <= 1'b0;
            r_active    <= 1'b0;
            r_finished  <= 1'b0;
            r_valid     <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SPACING:  r_spacing  <= i_cfg_data[15:0];
                    CFG_HISTORY:  r_history  <= i_cfg_data[23:0];
                    CFG_RECOVERY: r_recovery <= i_cfg_data[23:0];
                    CFG_TOL:      r_tol      <= i_cfg_data[15:0];
                    CFG_TIMEOUT:  r_timeout  <= i_cfg_data[15:0];
                    CFG_LEAST:    r_least    <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_cmd.set_cur) r_have_pose <= 1'b1;
            // full ring: the new crumb overwrites the oldest slot
            if (i_cmd.rec) begin
                if (r_count >= CNW'(CRUMB_DEPTH)) r_oldest <= slot_one;
                else                             r_count  <= r_count + CNW'(1);
            end
            if (i_cmd.trim) begin
                r_oldest <= slot_im2;
                r_count  <= r_count - (r_i - CNW'(2));
            end
            if (i_cmd.start_req) begin
                r_active   <= 1'b1;
                r_finished <= 1'b0;
            end
            if (i_cmd.fall_req) begin
                r_active   <= 1'b0;
                r_finished <= 1'b0;
                r_valid    <= 1'b0;
                r_elapsed  <= '0;
            end
            if (i_cmd.tick_inc && r_elapsed != 16'hFFFF) r_elapsed <= r_elapsed + 16'd1;
            if (i_cmd.fail) begin
                r_finished <= 1'b1;
                r_valid    <= 1'b0;
            end
            if (i_cmd.path_ok) begin
                r_valid   <= 1'b1;
                r_elapsed <= '0;
            end
            if (i_cmd.set_finished) r_finished <= 1'b1;
            if (i_cmd.pt_load || i_cmd.st_load) r_out_valid <= 1'b1;
            else if (!i_out_stall)              r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_level  <= i_request_level;
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
        end
        if (i_cmd.set_cur) begin
            r_cur_x <= r_px;
            r_cur_y <= r_py;
        end
        if (i_cmd.a_load) begin
            case (i_cmd.a_sel)
                A_CUR:   begin r_ax <= r_cur_x; r_ay <= r_cur_y; end
                A_RAM:   begin r_ax <= ram_x;   r_ay <= ram_y;   end
                default: begin r_ax <= r_bx;    r_ay <= r_by;    end
            endcase
        end
        if (i_cmd.b_load) begin
            case (i_cmd.b_sel)
                B_CUR:   begin r_bx <= r_cur_x;  r_by <= r_cur_y;  end
                B_RAM:   begin r_bx <= ram_x;    r_by <= ram_y;    end
                default: begin r_bx <= r_goal_x; r_by <= r_goal_y; end
            endcase
        end
        if (i_cmd.i_load_cnt) r_i <= r_count;
        if (i_cmd.i_dec)      r_i <= r_i - CNW'(1);
        if (i_cmd.len_clr)    r_len <= '0;
        if (i_cmd.len_add)    r_len <= len_sum;
        if (i_cmd.sp_init) begin
            r_station <= '0;
            r_n       <= PNW'(1);
            r_i       <= r_count;
            r_ax      <= r_cur_x;
            r_ay      <= r_cur_y;
        end
        if (i_cmd.keep) begin
            r_station <= st_sum;
            r_n       <= r_n + PNW'(1);
            r_ax      <= r_bx;
            r_ay      <= r_by;
        end
        if (i_cmd.path_ok) begin
            r_goal_x <= r_ax;
            r_goal_y <= r_ay;
            r_k      <= '0;
        end
        if (i_cmd.pt_load) begin
            r_k         <= r_k + PNW'(1);
            o_kind      <= 1'b0;
            o_point_x   <= path_q[PRW-1:PRW-COORD_WIDTH];
            o_point_y   <= path_q[OUT_W+COORD_WIDTH-1:OUT_W];
            o_station   <= path_q[OUT_W-1:0];
            o_run_state <= '0;
            o_reason    <= '0;
            o_ready_res <= 1'b0;
            o_remaining <= '0;
            o_last      <= 1'b0;
        end
        if (i_cmd.st_load) begin
            o_kind      <= 1'b1;
            o_point_x   <= '0;
            o_point_y   <= '0;
            o_station   <= '0;
            o_run_state <= st_run;
            o_reason    <= st_why;
            o_ready_res <= st_rdy;
            o_remaining <= sat24(st_rem);
            o_last      <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

[design/bcrp_ctrl.sv]
// Controller state machine: sequences record, trim, path build, point
// emission and tick checks over the datapath. Depends on bcrp_pkg.
`timescale 1ns / 1ps

module bcrp_ctrl
    import bcrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_EMIT,
        S_PR_RD, S_PR_LD, S_PR_GO, S_PR_WT, S_REC,
        S_TR_INIT, S_TR_RD0, S_TR_LD0, S_TR_RD, S_TR_LD, S_TR_GO, S_TR_WT,
        S_SP_CHK, S_SP_LOOP, S_SP_LD, S_SP_GO, S_SP_WT, S_SP_END,
        S_PT_RD, S_PT_OUT, S_TK_GO, S_TK_WT
    } t_state;

    t_state  r_state, n_state;
    t_stcode r_st_code, n_st_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_st_code <= ST_REC;
        end else begin
            r_state   <= n_state;
            r_st_code <= n_st_code;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_st_code     = r_st_code;
        o_cmd         = '0;
        o_cmd.st_code = r_st_code;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                unique case (i_stat.action)
                    ACT_POSE: begin
                        o_cmd.set_cur = 1'b1;
                        if (i_stat.req_active)    n_state = S_IDLE;
                        else if (i_stat.cnt_zero) n_state = S_REC;
                        else                      n_state = S_PR_RD;
                    end
                    ACT_REQ: begin
                        if (i_stat.level && !i_stat.req_active) begin
                            o_cmd.start_req = 1'b1;
                            n_state = S_SP_CHK;
                        end else if (!i_stat.level && i_stat.req_active) begin
                            o_cmd.fall_req = 1'b1;
                            n_st_code = ST_REC;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    ACT_TICK: begin
                        if (!i_stat.req_active) begin
                            n_st_code = ST_REC;
                            n_state = S_EMIT;
                        end else if (i_stat.finished || !i_stat.path_valid
                                     || !i_stat.have_pose) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.tick_inc = 1'b1;
                            o_cmd.a_load   = 1'b1;
                            o_cmd.a_sel    = A_CUR;
                            o_cmd.b_load   = 1'b1;
                            o_cmd.b_sel    = B_GOAL;
                            n_state = S_TK_GO;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.st_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PR_RD: begin
                o_cmd.rd_crumb = 1'b1;
                o_cmd.addr_sel = AD_CNT_M1;
                n_state = S_PR_LD;
            end
            S_PR_LD: begin
                o_cmd.a_load = 1'b1;
                o_cmd.a_sel  = A_RAM;
                o_cmd.b_load = 1'b1;
                o_cmd.b_sel  = B_CUR;
                n_state = S_PR_GO;
            end
            S_PR_GO: begin
                o_cmd.dist_go = 1'b1;
                n_state = S_PR_WT;
            end
            S_PR_WT: begin
                if (i_stat.dist_done) n_state = i_stat.d_ge_spacing ? S_REC : S_TR_INIT;
            end
            S_REC: begin
                o_cmd.rec = 1'b1;
                n_state = S_TR_INIT;
            end
            S_TR_INIT: begin
                o_cmd.i_load_cnt = 1'b1;
                o_cmd.len_clr    = 1'b1;
                n_state = i_stat.cnt_gt1 ? S_TR_RD0 : S_IDLE;
            end
            S_TR_RD0: begin
                o_cmd.rd_crumb = 1'b1;
                o_cmd.addr_sel = AD_I_M1;
                n_state = S_TR_LD0;
            end
            S_TR_LD0: begin
                o_cmd.a_load = 1'b1;
                o_cmd.a_sel  = A_RAM;
                n_state = S_TR_RD;
            end
            S_TR_RD: begin
                o_cmd.rd_crumb = 1'b1;
                o_cmd.addr_sel = AD_I_M2;
                n_state = S_TR_LD;
            end
            S_TR_LD: begin
                o_cmd.b_load = 1'b1;
                o_cmd.b_sel  = B_RAM;
                n_state = S_TR_GO;
            end
            S_TR_GO: begin
                o_cmd.dist_go = 1'b1;
                n_state = S_TR_WT;
            end
            S_TR_WT: begin
                if (i_stat.dist_done) begin
                    o_cmd.len_add = 1'b1;
                    if (i_stat.len_over) begin
                        o_cmd.trim = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.a_load = 1'b1;
                        o_cmd.a_sel  = A_B;
                        o_cmd.i_dec  = 1'b1;
                        n_state = i_stat.i_gt2 ? S_TR_RD : S_IDLE;
                    end
                end
            end
            S_SP_CHK: begin
                if (!i_stat.have_pose || i_stat.few) begin
                    o_cmd.fail = 1'b1;
                    n_st_code = ST_FEW;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.sp_init = 1'b1;
                    n_state = S_SP_LOOP;
                end
            end
            S_SP_LOOP: begin
                if (i_stat.i_pos) begin
                    o_cmd.rd_crumb = 1'b1;
                    o_cmd.addr_sel = AD_I_M1;
                    n_state = S_SP_LD;
                end else begin
                    n_state = S_SP_END;
                end
            end
            S_SP_LD: begin
                o_cmd.b_load = 1'b1;
                o_cmd.b_sel  = B_RAM;
                n_state = S_SP_GO;
            end
            S_SP_GO: begin
                o_cmd.dist_go = 1'b1;
                n_state = S_SP_WT;
            end
            S_SP_WT: begin
                if (i_stat.dist_done) begin
                    o_cmd.i_dec = 1'b1;
                    if (i_stat.seg_short) begin
                        n_state = S_SP_LOOP;
                    end else begin
                        o_cmd.keep = 1'b1;
                        n_state = i_stat.st_reach ? S_SP_END : S_SP_LOOP;
                    end
                end
            end
            S_SP_END: begin
                if (i_stat.path_short) begin
                    o_cmd.fail = 1'b1;
                    n_st_code = ST_SHORT;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.path_ok = 1'b1;
                    n_state = S_PT_RD;
                end
            end
            S_PT_RD: begin
                o_cmd.pt_rd = 1'b1;
                n_state = S_PT_OUT;
            end
            S_PT_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.pt_load = 1'b1;
                    if (i_stat.pt_more) begin
                        n_state = S_PT_RD;
                    end else begin
                        n_st_code = ST_PATHOK;
                        n_state = S_EMIT;
                    end
                end
            end
            S_TK_GO: begin
                o_cmd.dist_go = 1'b1;
                n_state = S_TK_WT;
            end
            S_TK_WT: begin
                if (i_stat.dist_done) begin
                    n_state = S_EMIT;
                    if (i_stat.at_goal) begin
                        o_cmd.set_finished = 1'b1;
                        n_st_code = ST_REACH;
                    end else if (i_stat.timed_out) begin
                        o_cmd.set_finished = 1'b1;
                        n_st_code = ST_TIMEOUT;
                    end else begin
                        n_st_code = ST_TRACK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[design/breadcrumb_reverse_path_planner.sv]
// Top level of the breadcrumb reverse path planner: controller plus datapath.
// Depends on bcrp_pkg, bcrp_ctrl, bcrp_dp (and through it bcrp_ram, bcrp_dist).
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall   | action, pos_x, pos_y, request
//   out     | output    | o_out_valid / i_out_stall | kind, point, station, status
//   cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item is worked at a time. Every distance goes through one shared unit:
// a squared-sum multiply and a 32-step root. A pose item computes one distance
// for the newest-crumb check, then one per crumb pair in the history trim walk.
// A rising request walks up to 32 crumbs the same way, then emits each path
// point through states S_PT_RD and S_PT_OUT, plus the status item. A tick item
// computes one distance, to the goal. Reset is synchronous, active low; the
// crumb ring needs no clearing pass since the count guards every read. A stalled
// output holds the block in its point or status emit state; inputs are stalled
// whenever the block is not idle.
`timescale 1ns / 1ps

module breadcrumb_reverse_path_planner
    import bcrp_pkg::*;
#(
    parameter int CRUMB_DEPTH = CRUMB_DEPTH_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic                          i_request_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic [OUT_W-1:0]              o_station,
    output logic [1:0]                    o_run_state,
    output logic [2:0]                    o_reason,
    output logic                          o_ready_res,
    output logic [OUT_W-1:0]              o_remaining,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing only; all data lives in the datapath
    bcrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bcrp_dp #(
        .CRUMB_DEPTH (CRUMB_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_action        (i_action),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_request_level (i_request_level),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_station       (o_station),
        .o_run_state     (o_run_state),
        .o_reason        (o_reason),
        .o_ready_res     (o_ready_res),
        .o_remaining     (o_remaining),
        .o_last          (o_last)
    );
endmodule

[bench/testbench.sv]
// Self-checking bench for breadcrumb_reverse_path_planner: a scoreboard class
// predicts every result item from the accepted input items and the registers.
// Depends on bcrp_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;
    import bcrp_pkg::*;

    localparam int CW = 24;
    localparam int DEPTH = 32;
    localparam int WATCH_LIMIT = 20000;   // cycles with nothing accepted
    localparam int SETTLE = 2000;         // longer than the slowest pose item
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam longint unsigned SAT = 64'hFFFFFF;

    typedef struct packed {
        logic                 kind;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic [23:0]          station;
        logic [1:0]           run_state;
        logic [2:0]           reason;
        logic                 ready;
        logic [23:0]          remaining;
        logic                 last;
    } t_plan_res;

    // Path planner predictor plus store of expected result items.
    class t_plan_scoreboard;
        t_plan_res pending[$];
        int        errors;
        longint unsigned spacing, hist_span, rec_span, tol, tmo, least;
        longint crumb_x[DEPTH], crumb_y[DEPTH];
        int        oldest, count;
        longint    cur_x, cur_y, goal_x, goal_y;
        bit        have_pose, req_active, finished, path_ok;
        longint unsigned ticks;

        function void clear();
            spacing = 51; hist_span = 3072; rec_span = 717;
            tol = 102; tmo = 60; least = 4;
            oldest = 0; count = 0;
            cur_x = 0; cur_y = 0; goal_x = 0; goal_y = 0;
            have_pose = 0; req_active = 0; finished = 0; path_ok = 0;
            ticks = 0; errors = 0;
            pending.delete();
        endfunction

        function void set_reg(t_cfg_idx idx, logic [23:0] v);
            case (idx)
                CFG_SPACING:  spacing = v[15:0];
                CFG_HISTORY:  hist_span = v;
                CFG_RECOVERY: rec_span = v;
                CFG_TOL:      tol = v[15:0];
                CFG_TIMEOUT:  tmo = v[15:0];
                default:      least = v[5:0];
            endcase
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // 24-bit coordinates: differences never need the halving path
        function longint unsigned span(longint ax, longint ay, longint bx, longint by);
            longint unsigned a, b;
            a = (ax > bx) ? ax - bx : bx - ax;
            b = (ay > by) ? ay - by : by - ay;
            return isqrt(a * a + b * b);
        endfunction

        function int slot(int i);
            return (oldest + i) % DEPTH;
        endfunction

        function longint unsigned sat(longint unsigned v);
            return (v > SAT) ? SAT : v;
        endfunction

        function void push(bit kind, longint px, longint py, longint unsigned st,
                           int rs, int why, bit rdy, longint unsigned rem, bit last);
            t_plan_res r;
            r.kind = kind;
            r.px = px[CW-1:0];
            r.py = py[CW-1:0];
            r.station = 24'(sat(st));
            r.run_state = 2'(rs);
            r.reason = 3'(why);
            r.ready = rdy;
            r.remaining = 24'(sat(rem));
            r.last = last;
            pending.insert(pending.size(), r);
        endfunction

        function void record_pose();
            longint unsigned length;
            int a, b;
            length = 0;
            if (count == 0 || span(crumb_x[slot(count-1)], crumb_y[slot(count-1)],
                                   cur_x, cur_y) >= spacing) begin
                if (count >= DEPTH) begin   // full store drops the oldest
                    oldest = (oldest + 1) % DEPTH;
                    count = DEPTH - 1;
                end
                crumb_x[slot(count)] = cur_x;
                crumb_y[slot(count)] = cur_y;
                count++;
            end
            for (int i = count; i > 1; i--) begin
                a = slot(i-1);
                b = slot(i-2);
                length += span(crumb_x[a], crumb_y[a], crumb_x[b], crumb_y[b]);
                if (length > hist_span) begin
                    oldest = slot(i-2);
                    count -= i - 2;
                    break;
                end
            end
        endfunction

        function void build_path();
            longint px[DEPTH+1], py[DEPTH+1];
            longint unsigned st[DEPTH+1];
            longint unsigned station, seg;
            longint prx, pry;
            int n, s;
            n = 1;
            station = 0;
            prx = cur_x;
            pry = cur_y;
            if (!have_pose || count < least) begin
                finished = 1; path_ok = 0;
                push(1, 0, 0, 0, RUN_FAIL, WHY_FEW, 0, 0, 1);
                return;
            end
            px[0] = cur_x; py[0] = cur_y; st[0] = 0;
            for (int i = count; i > 0; i--) begin
                s = slot(i-1);
                seg = span(prx, pry, crumb_x[s], crumb_y[s]);
                if (seg * 2 < spacing) continue;
                station += seg;
                px[n] = crumb_x[s]; py[n] = crumb_y[s]; st[n] = station;
                n++;
                prx = crumb_x[s]; pry = crumb_y[s];
                if (station >= rec_span) break;
            end
            if (n < least || station * 2 < rec_span) begin
                finished = 1; path_ok = 0;
                push(1, 0, 0, 0, RUN_FAIL, WHY_SHORT, 0, station, 1);
                return;
            end
            goal_x = px[n-1]; goal_y = py[n-1];
            path_ok = 1;
            ticks = 0;
            for (int k = 0; k < n; k++) push(0, px[k], py[k], st[k], 0, 0, 0, 0, 0);
            push(1, 0, 0, 0, RUN_REVERSE, WHY_REVERSE, 1, station, 1);
        endfunction

        // Called for each accepted input item.
        function void note_input(t_action act, logic signed [CW-1:0] x,
                                 logic signed [CW-1:0] y, logic lvl);
            longint unsigned rem;
            case (act)
                ACT_POSE: begin
                    cur_x = x; cur_y = y;
                    have_pose = 1;
                    if (!req_active) record_pose();
                end
                ACT_REQ: begin
                    if (lvl && !req_active) begin
                        req_active = 1; finished = 0;
                        build_path();
                    end else if (!lvl && req_active) begin
                        req_active = 0; finished = 0; path_ok = 0; ticks = 0;
                        push(1, 0, 0, 0, RUN_RECORD, WHY_RECORD, 0, 0, 1);
                    end
                end
                ACT_TICK: begin
                    if (!req_active) begin
                        push(1, 0, 0, 0, RUN_RECORD, WHY_RECORD, 0, 0, 1);
                    end else if (!finished && path_ok && have_pose) begin
                        if (ticks < 65535) ticks++;
                        rem = span(cur_x, cur_y, goal_x, goal_y);
                        if (rem <= tol) begin
                            finished = 1;
                            push(1, 0, 0, 0, RUN_DONE, WHY_REACHED, 0, rem, 1);
                        end else if (ticks > tmo) begin
                            finished = 1;
                            push(1, 0, 0, 0, RUN_FAIL, WHY_TIMEOUT, 0, rem, 1);
                        end else begin
                            push(1, 0, 0, 0, RUN_REVERSE, WHY_REVERSE, 1, rem, 1);
                        end
                    end
                end
                default: ;   // unknown action is ignored
            endcase
        endfunction

        function void check_result(t_plan_res got);
            t_plan_res want;
            if (pending.size() == 0) begin
                errors++;
                $error("result item with nothing expected: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind) begin
                errors++; $error("kind exp %0d got %0d", want.kind, got.kind);
            end
            if (got.px !== want.px) begin
                errors++; $error("point_x exp %0d got %0d", want.px, got.px);
            end
            if (got.py !== want.py) begin
                errors++; $error("point_y exp %0d got %0d", want.py, got.py);
            end
            if (got.station !== want.station) begin
                errors++; $error("station exp %0d got %0d", want.station, got.station);
            end
            if (got.run_state !== want.run_state) begin
                errors++; $error("run_state exp %0d got %0d", want.run_state, got.run_state);
            end
            if (got.reason !== want.reason) begin
                errors++; $error("reason exp %0d got %0d", want.reason, got.reason);
            end
            if (got.ready !== want.ready) begin
                errors++; $error("ready_res exp %0d got %0d", want.ready, got.ready);
            end
            if (got.remaining !== want.remaining) begin
                errors++; $error("remaining exp %0d got %0d", want.remaining, got.remaining);
            end
            if (got.last !== want.last) begin
                errors++; $error("last exp %0d got %0d", want.last, got.last);
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_in_valid = 0;
    logic                 o_in_stall;
    logic [1:0]           i_action = '0;
    logic signed [CW-1:0] i_pos_x = '0;
    logic signed [CW-1:0] i_pos_y = '0;
    logic                 i_request_level = 0;
    logic                 o_out_valid;
    logic                 i_out_stall = 0;
    logic                 o_kind;
    logic signed [CW-1:0] o_point_x, o_point_y;
    logic [OUT_W-1:0]     o_station, o_remaining;
    logic [1:0]           o_run_state;
    logic [2:0]           o_reason;
    logic                 o_ready_res, o_last;
    logic                 i_cfg_we = 0;
    logic [2:0]           i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    breadcrumb_reverse_path_planner u_top (.*);

    t_plan_scoreboard sb = new();
    bit idle_on;        // random gaps/stalls allowed
    bit hold_req;       // receiver long hold-off requested
    bit tail;           // final stretch: no idling, no hold-off
    int items_sent;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: checks results, stalls in bursts, honors the long hold-off.
    initial begin : receiver
        int burst;
        t_plan_res got;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = '{o_kind, o_point_x, o_point_y, o_station, o_run_state,
                        o_reason, o_ready_res, o_remaining, o_last};
                sb.check_result(got);
            end
            if (hold_req) begin
                i_out_stall <= 1;
                for (int k = 1; k < HOLD_CYCLES; k++) @(posedge i_clk);
                hold_req = 0;
                i_out_stall <= 0;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 7);
                i_out_stall <= 1;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    // Watchdog: cycles in which neither channel nor the config port moves.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCH_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one item, optionally after a gap; valid stays high afterwards.
    task automatic send_item(t_action act, logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y, logic lvl);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_action <= act;
        i_pos_x <= x;
        i_pos_y <= y;
        i_request_level <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(act, x, y, lvl);
        items_sent++;
    endtask

    function automatic logic signed [CW-1:0] clamp(longint v);
        if (v > 8388607) return CW'(8388607);
        if (v < -8388608) return CW'(-8388608);
        return CW'(v);
    endfunction

    task automatic send_pose(longint x, longint y);
        send_item(ACT_POSE, clamp(x), clamp(y), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_req(bit lvl);
        send_item(ACT_REQ, CW'($urandom), CW'($urandom), lvl);
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, CW'($urandom), CW'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Registers change only with the block idle: drain, let it settle, write all.
    task automatic write_regs(logic [23:0] spc, logic [23:0] hst, logic [23:0] rcv,
                              logic [23:0] tl, logic [23:0] tmo, logic [23:0] lst);
        logic [23:0] vals[6];
        vals = '{spc, hst, rcv, tl, tmo, lst};
        i_in_valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        for (int k = 0; k < 6; k++) begin
            i_cfg_we <= 1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            sb.set_reg(t_cfg_idx'(k), vals[k]);
        end
        i_cfg_we <= 0;
    endtask

    // One record / reverse / release cycle with random content.
    task automatic mission();
        longint x, y, stp;
        int npose, nlate;
        x = $signed($urandom_range(0, 8000000)) - 4000000;
        y = $signed($urandom_range(0, 8000000)) - 4000000;
        stp = (sb.spacing * $urandom_range(5, 30)) / 10 + 1;
        npose = $urandom_range(3, 16);
        if (!tail) idle_on = $urandom_range(0, 3) != 0;
        for (int k = 0; k < npose; k++) begin
            x += $signed($urandom_range(0, 2 * stp)) - stp;
            y += $signed($urandom_range(0, 2 * stp)) - stp;
            send_pose(x, y);
            if ($urandom_range(0, 19) == 0)
                send_item(ACT_NONE, CW'($urandom), CW'($urandom), 1);
        end
        if (!tail && $urandom_range(0, 5) == 0) hold_req = 1;
        send_req(1);
        if ($urandom_range(0, 9) == 0) send_req(1);   // no change
        nlate = $urandom_range(1, 8);
        for (int k = 0; k < nlate; k++) begin
            case ($urandom_range(0, 3))
                0: send_pose(sb.goal_x + $signed($urandom_range(0, 2 * sb.tol)) - sb.tol,
                             sb.goal_y + $signed($urandom_range(0, 2 * sb.tol)) - sb.tol);
                1: send_pose(x + $signed($urandom_range(0, 2 * stp)) - stp, y);
                default: send_tick();
            endcase
        end
        send_tick();
        send_req(0);
    endtask

    initial begin : stimulus
        sb.clear();
        idle_on = 1;
        hold_req = 0;
        tail = 0;
        items_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: idle tick, unchanged request, unknown action, request with
        // no pose, tick after a failed start, extreme positions, pose while
        // requested, and a falling request.
        send_tick();
        send_req(0);
        send_item(ACT_NONE, 24'hFFFFFF, 24'hFFFFFF, 1);
        send_req(1);
        send_tick();
        send_req(1);
        send_req(0);
        send_pose(-8388608, -8388608);
        send_pose(8388607, 8388607);
        send_pose(8388607, -8388608);
        send_pose(-8388608, 8388607);
        send_pose(0, 0);
        for (int k = 1; k <= 6; k++) send_pose(k * 200, k * 150);
        hold_req = 1;
        send_req(1);
        send_pose(1000, 750);
        send_tick();
        send_pose(sb.goal_x, sb.goal_y);
        send_tick();
        send_tick();
        send_req(0);

        // Random missions across register settings, extremes among them.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: ;
                1: write_regs(1, 1, 1, 1, 1, 2);
                2: write_regs(100, 6000, 1500, 300, 3, 3);
                3: write_regs(65535, 24'hFFFFFF, 24'hFFFFFF, 65535, 65535, 33);
                4: write_regs(20, 2000, 400, 60, 8, 2);
                default: write_regs(51, 3072, 717, 102, 60, 4);
            endcase
            if (phase == 5) begin
                tail = 1;
                idle_on = 0;
            end
            while (items_sent < 40 + phase * 52) begin
                mission();
                // full-range noise so every input bit toggles
                if ($urandom_range(0, 2) == 0)
                    send_item(t_action'($urandom_range(0, 3)), CW'($urandom),
                              CW'($urandom), 1'($urandom_range(0, 1)));
            end
        end

        i_in_valid <= 0;
        wait (sb.pending.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.errors++;
            $error("%0d expected result items never arrived", sb.pending.size());
        end
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
design/bcrp_pkg.sv
design/bcrp_ram.sv
design/bcrp_dist.sv
design/bcrp_dp.sv
design/bcrp_ctrl.sv
design/breadcrumb_reverse_path_planner.sv
bench/testbench.sv
